### hw/rtl/gf256_arithmetic_unit_top_assert.svh
// Assertion macros for the GF(2^8) arithmetic unit RTL, used by the front stage.
`ifndef GF256_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define GF256_ARITHMETIC_UNIT_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define GFAU_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define GFAU_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define GFAU_ASSERT(label, prop, msg)
`define GFAU_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### hw/rtl/gfau_pkg.sv
// Package with types, codes and field arithmetic for the GF(2^8) arithmetic unit.
`timescale 1ns / 1ps

package gfau_pkg;

   localparam logic [2:0] CMD_XOR = 3'd0;
   localparam logic [2:0] CMD_MUL = 3'd1;
   localparam logic [2:0] CMD_DIV = 3'd2;
   localparam logic [2:0] CMD_INV = 3'd3;
   localparam logic [2:0] CMD_POW = 3'd4;

   localparam logic [7:0] FIELD_RED   = 8'h1D;
   localparam logic [8:0] GROUP_ORDER = 9'd255;
   localparam logic [7:0] INV_EXP     = 8'd254;
   localparam int         POW_STAGES  = 8;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] acc;
      logic [7:0] sq;
      logic [7:0] e8;
   } gfau_stage_type;

   function automatic logic [7:0] gf_mul(input logic [7:0] x_in, input logic [7:0] y_in);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'h00;
      x   = x_in;
      for (int i = 0; i < 8; i++) begin
         if (y_in[i]) begin
            acc = acc ^ x;
         end
         if (x[7]) begin
            x = {x[6:0], 1'b0} ^ FIELD_RED;
         end else begin
            x = {x[6:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

### hw/rtl/gfau_front.sv
// Input stage: command decode, base selection and exponent reduction modulo 255.
`timescale 1ns / 1ps

module gfau_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [gfau_pkg::REQ_DATA_W-1:0]     in_data,
   output logic                                out_valid,
   input  logic                                out_ready,
   output gfau_pkg::gfau_stage_type            out_data
);
   import gfau_pkg::*;
   `include "gf256_arithmetic_unit_top_assert.svh"

   logic [2:0]     cmd;
   logic [7:0]     op_a;
   logic [7:0]     op_b;
   logic [15:0]    exp_raw;
   logic [8:0]     exp_sum;
   logic [8:0]     exp_mod9;
   logic [7:0]     exp_mod;
   logic           valid_ff;
   gfau_stage_type stage_ff;
   gfau_stage_type stage_in;

   assign cmd     = in_data[2:0];
   assign op_a    = in_data[10:3];
   assign op_b    = in_data[18:11];
   assign exp_raw = in_data[34:19];

   // 256 is 1 modulo 255, so the low byte and bits 14:8 of the exponent simply add.
   assign exp_sum  = {1'b0, exp_raw[7:0]} + {2'b00, exp_raw[14:8]};
   assign exp_mod9 = (exp_sum >= GROUP_ORDER) ? (exp_sum - GROUP_ORDER) : exp_sum;
   assign exp_mod  = exp_mod9[7:0];

   always_comb begin
      stage_in     = '0;
      stage_in.cmd = cmd;
      stage_in.a   = op_a;
      stage_in.b   = op_b;
      stage_in.acc = 8'h01;
      stage_in.sq  = op_a;
      stage_in.e8  = 8'h00;
      case (cmd)
         CMD_DIV: begin
            stage_in.sq = op_b;
            stage_in.e8 = INV_EXP;
         end
         CMD_INV: begin
            stage_in.e8 = INV_EXP;
         end
         CMD_POW: begin
            // A zero base with a positive exponent must give zero, so it runs as 0^1.
            if (exp_raw == 16'h0000 || exp_raw[15]) begin
               stage_in.e8 = 8'h00;
            end else if (op_a == 8'h00) begin
               stage_in.e8 = 8'h01;
            end else begin
               stage_in.e8 = exp_mod;
            end
         end
         default: begin
            stage_in.e8 = 8'h00;
         end
      endcase
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = stage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         stage_ff <= stage_in;
      end
   end

   `GFAU_ASSERT(a_exp_reduced, valid_ff |-> (stage_ff.e8 != 8'hFF), "exponent not reduced")
   `GFAU_ASSERT(a_neg_exp_one,
      (in_valid && in_ready && cmd == CMD_POW && exp_raw[15]) |=> (stage_ff.e8 == 8'h00),
      "negative exponent not forced to zero")
   `GFAU_ASSERT(a_div_setup,
      (in_valid && in_ready && cmd == CMD_DIV) |=> (stage_ff.e8 == INV_EXP && stage_ff.sq == stage_ff.b),
      "divide not set up as divisor inverse")
   `GFAU_ASSERT(a_stall_hold,
      (valid_ff && !out_ready) |=> (valid_ff && $stable(stage_ff)),
      "front stage lost a stalled item")

endmodule

### hw/rtl/gfau_pow_stage.sv
// One square-and-multiply step of the exponentiation pipeline.
`timescale 1ns / 1ps

module gfau_pow_stage (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  gfau_pkg::gfau_stage_type in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output gfau_pkg::gfau_stage_type out_data
);
   import gfau_pkg::*;

   logic           valid_ff;
   gfau_stage_type stage_ff;
   gfau_stage_type stage_in;

   always_comb begin
      stage_in     = in_data;
      stage_in.acc = in_data.e8[0] ? gf_mul(in_data.acc, in_data.sq) : in_data.acc;
      stage_in.sq  = gf_mul(in_data.sq, in_data.sq);
      stage_in.e8  = {1'b0, in_data.e8[7:1]};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = stage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         stage_ff <= stage_in;
      end
   end

endmodule

### hw/rtl/gfau_back.sv
// Output stage: final multiply, result selection and the result register.
`timescale 1ns / 1ps

module gfau_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  gfau_pkg::gfau_stage_type in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [7:0]               out_result
);
   import gfau_pkg::*;

   logic       valid_ff;
   logic [7:0] result_ff;
   logic [7:0] result_in;
   logic [7:0] mul_rhs;

   assign mul_rhs = (in_data.cmd == CMD_DIV) ? in_data.acc : in_data.b;

   always_comb begin
      case (in_data.cmd)
         CMD_XOR: result_in = in_data.a ^ in_data.b;
         CMD_MUL: result_in = gf_mul(in_data.a, mul_rhs);
         CMD_DIV: result_in = gf_mul(in_data.a, mul_rhs);
         CMD_INV: result_in = in_data.acc;
         CMD_POW: result_in = in_data.acc;
         default: result_in = 8'h00;
      endcase
   end

   assign in_ready   = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         result_ff <= result_in;
      end
   end

endmodule

### hw/rtl/gf256_arithmetic_unit_top.sv
// Top level of the GF(2^8) arithmetic unit, polynomial 0x11D.
//
//   Channel   Direction   Ports           Item
//   req       in          req_tvalid/...  cmd, operand_a, operand_b, exponent
//   rsp       out         rsp_tvalid/...  result
//
// One item enters per cycle while rsp_tready does not stall the pipeline. Its result is
// registered by the front stage, eight square-and-multiply stages and the output stage
// in that order before it shows on rsp_tdata; each of these stages has its own register
// and valid bit.
// Each stage holds its item while the next one is full, so empty stages keep filling
// while a result waits on rsp_tready. Synchronous reset clears all valid bits.
`timescale 1ns / 1ps

module gf256_arithmetic_unit_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // cmd[2:0], operand_a[10:3], operand_b[18:11], exponent[34:19], zero pad[39:35]
   input  logic [gfau_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // result[7:0]
   output logic [gfau_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import gfau_pkg::*;

   logic           chain_valid [POW_STAGES+1];
   logic           chain_ready [POW_STAGES+1];
   gfau_stage_type chain_data  [POW_STAGES+1];

   gfau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   for (genvar k = 0; k < POW_STAGES; k++) begin : g_pow
      gfau_pow_stage u_pow (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_data  (chain_data[k+1])
      );
   end

   gfau_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (chain_valid[POW_STAGES]),
      .in_ready   (chain_ready[POW_STAGES]),
      .in_data    (chain_data[POW_STAGES]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (rsp_tdata)
   );

endmodule
